[rtl/block_transfer_tracker_unit_macros.svh]
// Assertion macros for the block transfer tracker.
`ifndef BLOCK_TRANSFER_TRACKER_UNIT_MACROS_SVH
`define BLOCK_TRANSFER_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BTT_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("btt assertion failed");
// next-cycle implication
`define BTT_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("btt assertion failed");
`else
`define BTT_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define BTT_ASSERT_NXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

[rtl/btt_pkg.sv]
package btt_pkg;

	localparam logic [1:0] FUNC_FRAME = 2'd0;
	localparam logic [1:0] FUNC_RESET = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ACK_OK    = 2'd0;
	localparam logic [1:0] ACK_CRC   = 2'd1;
	localparam logic [1:0] ACK_RANGE = 2'd2;

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [3:0] POS_ID_LO   = 4'd1;
	localparam logic [3:0] POS_ID_HI   = 4'd2;
	localparam logic [3:0] POS_TOT_LO  = 4'd3;
	localparam logic [3:0] POS_TOT_HI  = 4'd4;
	localparam logic [3:0] POS_CFG     = 4'd5;
	localparam logic [3:0] POS_TAIL    = 4'd6;
	localparam logic [3:0] POS_MIN_END = 4'd7;
	localparam logic [3:0] POS_FOLD    = 4'd8;
	localparam logic [3:0] POS_MAX     = 4'd15;

	typedef struct packed {
		logic        done;
		logic        crc_ok;
		logic [15:0] blk_num;
		logic [15:0] total;
		logic [7:0]  cfg;
	} frame_end_t;

	typedef struct packed {
		logic clear_all;
		logic wr_en;
	} map_ctl_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[rtl/btt_frame.sv]
module btt_frame
	import btt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	input  logic             last_in,
	output frame_end_t       fe,
	output logic [15:0]      blk_num
);

	logic [3:0]  pos_q;
	logic [15:0] id_q, id_n;
	logic [15:0] tot_q, tot_n;
	logic [7:0]  cfg_q, cfg_n;
	logic [15:0] crc_q, crc_n;
	logic [15:0] tail_q, tail_n;

	always_comb begin
		id_n   = id_q;
		tot_n  = tot_q;
		cfg_n  = cfg_q;
		crc_n  = crc_q;
		tail_n = tail_q;
		case (pos_q)
			POS_ID_LO:  id_n  = {8'h00, byte_in};
			POS_ID_HI:  id_n  = {byte_in, id_q[7:0]};
			POS_TOT_LO: tot_n = {8'h00, byte_in};
			POS_TOT_HI: tot_n = {byte_in, tot_q[7:0]};
			POS_CFG:    cfg_n = byte_in;
			default: ;
		endcase
		if (pos_q >= POS_TAIL) begin
			if (pos_q >= POS_FOLD) begin
				crc_n = crc_fold(crc_q, tail_q[15:8]);
			end
			tail_n = {tail_q[7:0], byte_in};
		end
	end

	assign fe.done     = last_in && (pos_q >= POS_MIN_END);
	assign fe.crc_ok   = (crc_n == {tail_n[7:0], tail_n[15:8]});
	assign fe.blk_num  = id_n;
	assign fe.total    = tot_n;
	assign fe.cfg      = cfg_n;
	assign blk_num     = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			id_q   <= '0;
			tot_q  <= '0;
			cfg_q  <= '0;
			crc_q  <= CRC_INIT;
			tail_q <= '0;
		end else if (step) begin
			if (last_in) begin
				pos_q  <= '0;
				id_q   <= '0;
				tot_q  <= '0;
				cfg_q  <= '0;
				crc_q  <= CRC_INIT;
				tail_q <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 4'd1;
				end
				id_q   <= id_n;
				tot_q  <= tot_n;
				cfg_q  <= cfg_n;
				crc_q  <= crc_n;
				tail_q <= tail_n;
			end
		end
	end

endmodule

[rtl/btt_map.sv]
module btt_map
	import btt_pkg::*;
#(
	parameter int ROW_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  map_ctl_t         ctl,
	input  logic [ROW_W-1:0] wr_row,
	input  logic [7:0]       wr_data,
	input  logic             rda_en,
	input  logic [ROW_W-1:0] rda_row,
	output logic [7:0]       rda_data,
	input  logic [ROW_W-1:0] rdb_row,
	output logic [7:0]       rdb_data
);

	localparam int ROWS = 1 << ROW_W;

	logic [7:0]       mem [ROWS];
	logic [ROWS-1:0]  vld_q, vld_n;
	logic [7:0]       rda_q, rdb_q;
	logic [ROW_W-1:0] rda_row_q, rdb_row_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_row] <= wr_data;
		end
	end

	// reads see a write landing on the same edge
	always_ff @(posedge clk) begin
		if (rda_en) begin
			rda_q     <= (ctl.wr_en && wr_row == rda_row) ? wr_data : mem[rda_row];
			rda_row_q <= rda_row;
		end
		rdb_q     <= (ctl.wr_en && wr_row == rdb_row) ? wr_data : mem[rdb_row];
		rdb_row_q <= rdb_row;
	end

	always_comb begin
		vld_n = ctl.clear_all ? '0 : vld_q;
		if (ctl.wr_en) begin
			vld_n[wr_row] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_n;
		end
	end

	assign rda_data = vld_q[rda_row_q] ? rda_q : 8'h00;
	assign rdb_data = vld_q[rdb_row_q] ? rdb_q : 8'h00;

endmodule

[rtl/block_transfer_tracker_unit.sv]
// An accepted input beat passes the input register and then the result register; beats that
// give no result leave after the input register. Throughput: one input beat per cycle while the
// output is not stalled; a stalled result register holds back the input register.
// Reset (arst_n low): frame assembly, counters, session, active flag and bitmap valid bits
// clear at once; display_ready resets to 0. No clearing pass follows.
`include "block_transfer_tracker_unit_macros.svh"
module block_transfer_tracker_unit
	import btt_pkg::*;
#(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,        // display_ready
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // data_byte[7:0], has_session[8], bitmap_index[15:9]
	input  logic [1:0]  s_axis_tuser,    // func
	input  logic        s_axis_tlast,    // frame_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,    // blk_num[15:0], ack_status[17:16],
	                                     // write_payload[18], cfg_byte[26:19],
	                                     // total_count[37:27], received_count[48:38],
	                                     // session_value[56:49], active_flag[57],
	                                     // bitmap_byte[65:58], zero[71:66]
	output logic        m_axis_tuser     // kind
);

	localparam int MAP_BYTES = (MAX_BLOCKS + 7) / 8;
	localparam int ROW_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
	localparam logic [16:0] MAXB = 17'(MAX_BLOCKS);

	logic        display_ready_q;
	logic        s1_valid_q;
	logic [1:0]  func_s1;
	logic [7:0]  byte_s1;
	logic        sess_s1;
	logic        last_s1;
	logic [6:0]  idx_s1;

	logic             out_free, proc, acc, frame_step;
	frame_end_t       fe;
	logic [15:0]      cur_id;
	logic [7:0]       rda_data, rdb_data;
	map_ctl_t         map_ctl;
	logic [ROW_W-1:0] wr_row;
	logic [7:0]       wr_data;

	logic [CNT_W-1:0] expected_q, received_q;
	logic [7:0]       session_q;
	logic             on_q;

	logic        ack_go, range_bad, good, clr, seen, map_wr, is_query, emit, idx_ok;
	logic [1:0]  status;
	logic [7:0]  bmask, row_eff;

	logic        m_valid_q;
	logic        out_kind_q;
	logic [15:0] out_id_q;
	logic [1:0]  out_status_q;
	logic        out_wp_q;
	logic [7:0]  out_cfg_q;
	logic [10:0] out_total_q;
	logic [10:0] out_recv_q;
	logic [7:0]  out_sess_q;
	logic        out_act_q;
	logic [7:0]  out_bmap_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_ready_q <= 1'b0;
		end else if (cfg_valid) begin
			display_ready_q <= cfg_data;
		end
	end

	// input register
	assign out_free      = !m_valid_q || m_axis_tready;
	assign proc          = s1_valid_q && out_free;
	assign s_axis_tready = !s1_valid_q || out_free;
	assign acc           = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (proc) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
			sess_s1 <= s_axis_tdata[8];
			idx_s1  <= s_axis_tdata[15:9];
			last_s1 <= s_axis_tlast;
		end
	end

	assign frame_step = proc && (func_s1 == FUNC_FRAME);

	btt_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (frame_step),
		.byte_in  (byte_s1),
		.last_in  (last_s1),
		.fe       (fe),
		.blk_num  (cur_id)
	);

	// block end decision
	assign ack_go    = frame_step && fe.done && display_ready_q;
	assign range_bad = ({1'b0, fe.blk_num} >= MAXB) || (fe.blk_num >= fe.total)
	                   || (fe.total == 16'd0) || ({1'b0, fe.total} > MAXB);
	assign status    = !fe.crc_ok ? ACK_CRC : (range_bad ? ACK_RANGE : ACK_OK);
	assign good      = ack_go && fe.crc_ok && !range_bad;
	assign clr       = (fe.blk_num == 16'd0) || !on_q
	                   || (17'(expected_q) != {1'b0, fe.total});
	assign bmask     = 8'd1 << fe.blk_num[2:0];
	assign row_eff   = clr ? 8'h00 : rdb_data;
	assign seen      = |(row_eff & bmask);
	assign map_wr    = good && !seen;

	assign map_ctl.wr_en     = map_wr;
	assign map_ctl.clear_all = (good && clr) || (proc && func_s1 == FUNC_RESET);
	assign wr_row            = ROW_W'(fe.blk_num >> 3);
	assign wr_data           = row_eff | bmask;

	btt_map #(
		.ROW_W (ROW_W)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (map_ctl),
		.wr_row   (wr_row),
		.wr_data  (wr_data),
		.rda_en   (acc),
		.rda_row  (ROW_W'(s_axis_tdata[15:9])),
		.rda_data (rda_data),
		.rdb_row  (ROW_W'(cur_id >> 3)),
		.rdb_data (rdb_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			received_q <= '0;
			session_q  <= '0;
			on_q       <= 1'b0;
		end else if (proc && func_s1 == FUNC_RESET) begin
			expected_q <= '0;
			received_q <= '0;
			session_q  <= sess_s1 ? byte_s1 : 8'h00;
			on_q       <= 1'b0;
		end else if (good) begin
			expected_q <= CNT_W'(fe.total);
			received_q <= (clr ? '0 : received_q) + CNT_W'(map_wr);
			on_q       <= 1'b1;
		end
	end

	// result register
	assign is_query = (func_s1 == FUNC_QUERY);
	assign emit     = ack_go || is_query;
	assign idx_ok   = ({25'd0, idx_s1} < 32'(MAP_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (proc) begin
			m_valid_q <= emit;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			if (is_query) begin
				out_kind_q   <= KIND_STATUS;
				out_id_q     <= '0;
				out_status_q <= ACK_OK;
				out_wp_q     <= 1'b0;
				out_cfg_q    <= '0;
				out_total_q  <= 11'(expected_q);
				out_recv_q   <= 11'(received_q);
				out_sess_q   <= session_q;
				out_act_q    <= on_q;
				out_bmap_q   <= idx_ok ? rda_data : 8'h00;
			end else begin
				out_kind_q   <= KIND_ACK;
				out_id_q     <= fe.blk_num;
				out_status_q <= status;
				out_wp_q     <= map_wr;
				out_cfg_q    <= fe.cfg;
				out_total_q  <= '0;
				out_recv_q   <= '0;
				out_sess_q   <= '0;
				out_act_q    <= 1'b0;
				out_bmap_q   <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {6'd0, out_bmap_q, out_act_q, out_sess_q, out_recv_q, out_total_q,
	                        out_cfg_q, out_wp_q, out_status_q, out_id_q};

	`BTT_ASSERT_IMP(a_recv_le_total, clk, arst_n, 1'b1, received_q <= expected_q)
	`BTT_ASSERT_IMP(a_wp_ok, clk, arst_n, m_valid_q && out_wp_q, {out_kind_q, out_status_q} == {KIND_ACK, ACK_OK})
	`BTT_ASSERT_NXT(a_commit_sets_active, clk, arst_n, map_wr, on_q)

endmodule
